### hw/rtl/mts_pkg.sv
package mts_pkg;

  // fixed field widths
  localparam int unsigned MS_W          = 10;
  localparam int unsigned SEC_W         = 6;
  localparam int unsigned WIN_W         = 11;
  localparam int unsigned STARTUP_W     = 16;
  localparam int unsigned CAP_IN_W      = 8;
  localparam int unsigned CAP_LIMIT_W   = 8;
  localparam int unsigned TIMEOUT_REG_W = 16;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  // timebase constants
  localparam int unsigned MS_PER_SEC   = 1000;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned MIN_PER_HOUR = 60;
  localparam int unsigned WINDOW_TICKS = 1500;
  localparam int unsigned MS_DIV_10    = 10;
  localparam int unsigned MS_DIV_100   = 100;

  // parameter defaults
  localparam int unsigned CAPTURE_CHANNELS_DEF = 8;
  localparam int unsigned TIMEOUT_WIDTH_DEF    = 16;

  // register reset values
  localparam logic [TIMEOUT_REG_W-1:0] COM_TIMEOUT_RST = TIMEOUT_REG_W'(100);
  localparam logic [CAP_LIMIT_W-1:0]   CAP_TIMEOUT_RST = CAP_LIMIT_W'(3);
  localparam logic                     SCAN_MODE_RST   = 1'b1;
  localparam logic [STARTUP_W-1:0]     STARTUP_RST     = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_COM_TIMEOUT = 2'd0,
    REG_CAP_TIMEOUT = 2'd1,
    REG_SCAN_MODE   = 2'd2,
    REG_STARTUP     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic                window_start;
    logic                com1_rx;
    logic                com2_rx;
    logic [CAP_IN_W-1:0] cap_used;
    logic [CAP_IN_W-1:0] cap_edge;
  } item_t;

  typedef struct packed {
    logic                 pulse_10ms;
    logic                 pulse_100ms;
    logic                 scan_pulse;
    logic                 pulse_1s;
    logic                 pulse_1min;
    logic                 window_done;
    logic                 com1_flush;
    logic                 com2_flush;
    logic [CAP_IN_W-1:0]  freq_zero;
    logic [STARTUP_W-1:0] startup_left;
    logic [SEC_W-1:0]     seconds_now;
    logic [SEC_W-1:0]     minutes_now;
  } result_t;

  // timebase status handed to the top level
  typedef struct packed {
    logic                 pulse_10ms;
    logic                 pulse_100ms;
    logic                 scan_pulse;
    logic                 pulse_1s;
    logic                 pulse_1min;
    logic                 window_done;
    logic [STARTUP_W-1:0] startup_left;
    logic [SEC_W-1:0]     seconds_now;
    logic [SEC_W-1:0]     minutes_now;
  } tb_status_t;

endpackage

### hw/rtl/mts_timebase.sv
module mts_timebase (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             window_start,
  input  logic                             scan_mode,
  input  logic                             load_startup,
  input  logic [mts_pkg::STARTUP_W-1:0]    startup_value,
  output mts_pkg::tb_status_t              status
);

  localparam logic [mts_pkg::MS_W-1:0]  MS_LAST   = mts_pkg::MS_W'(mts_pkg::MS_PER_SEC - 1);
  localparam logic [3:0]                ONES_LAST = 4'(mts_pkg::MS_DIV_10 - 1);
  localparam logic [6:0]                HUND_LAST = 7'(mts_pkg::MS_DIV_100 - 1);
  localparam logic [mts_pkg::SEC_W-1:0] SEC_LAST  = mts_pkg::SEC_W'(mts_pkg::SEC_PER_MIN - 1);
  localparam logic [mts_pkg::SEC_W-1:0] MIN_LAST  = mts_pkg::SEC_W'(mts_pkg::MIN_PER_HOUR - 1);
  localparam logic [mts_pkg::WIN_W-1:0] WIN_LAST  = mts_pkg::WIN_W'(mts_pkg::WINDOW_TICKS - 1);

  logic [mts_pkg::MS_W-1:0]      ms_count, ms_count_next;
  logic [3:0]                    ms_ones, ms_ones_next;
  logic [6:0]                    ms_hund, ms_hund_next;
  logic [mts_pkg::SEC_W-1:0]     sec_count, sec_count_next;
  logic [mts_pkg::SEC_W-1:0]     min_count, min_count_next;
  logic                          window_active, window_active_next;
  logic [mts_pkg::WIN_W-1:0]     window_count, window_count_next;
  logic [mts_pkg::STARTUP_W-1:0] startup_count, startup_count_next;
  logic                          sec_tick, min_tick, win_on, win_close;

  always_comb begin
    sec_tick  = (ms_count == MS_LAST);
    min_tick  = sec_tick && (sec_count == SEC_LAST);
    win_on    = window_active || window_start;
    win_close = win_on && (window_count == WIN_LAST);

    ms_count_next = sec_tick ? '0 : ms_count + 1'b1;
    ms_ones_next  = (ms_ones == ONES_LAST) ? '0 : ms_ones + 1'b1;
    ms_hund_next  = (ms_hund == HUND_LAST) ? '0 : ms_hund + 1'b1;

    sec_count_next = sec_count;
    if (sec_tick) begin
      sec_count_next = (sec_count == SEC_LAST) ? '0 : sec_count + 1'b1;
    end
    min_count_next = min_count;
    if (min_tick) begin
      min_count_next = (min_count == MIN_LAST) ? '0 : min_count + 1'b1;
    end

    startup_count_next = startup_count;
    if (sec_tick && (startup_count != '0)) begin
      startup_count_next = startup_count - 1'b1;
    end

    // rearm while open keeps the running count
    window_active_next = win_on && !win_close;
    window_count_next  = window_count;
    if (win_close) begin
      window_count_next = '0;
    end else if (win_on) begin
      window_count_next = window_count + 1'b1;
    end

    status.pulse_10ms   = (ms_ones == ONES_LAST);
    status.pulse_100ms  = (ms_hund == HUND_LAST);
    status.scan_pulse   = scan_mode ? status.pulse_10ms : status.pulse_100ms;
    status.pulse_1s     = sec_tick;
    status.pulse_1min   = min_tick;
    status.window_done  = win_close;
    status.startup_left = startup_count_next;
    status.seconds_now  = sec_count_next;
    status.minutes_now  = min_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_count      <= '0;
      ms_ones       <= '0;
      ms_hund       <= '0;
      sec_count     <= '0;
      min_count     <= '0;
      window_active <= 1'b0;
      window_count  <= '0;
      startup_count <= mts_pkg::STARTUP_RST;
    end else begin
      if (step) begin
        ms_count      <= ms_count_next;
        ms_ones       <= ms_ones_next;
        ms_hund       <= ms_hund_next;
        sec_count     <= sec_count_next;
        min_count     <= min_count_next;
        window_active <= window_active_next;
        window_count  <= window_count_next;
        startup_count <= startup_count_next;
      end
      if (load_startup) begin
        startup_count <= startup_value;
      end
    end
  end

endmodule

### hw/rtl/mts_rx_timeout.sv
module mts_rx_timeout #(
  parameter int unsigned TIMEOUT_WIDTH = mts_pkg::TIMEOUT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              rx,
  input  logic [mts_pkg::TIMEOUT_REG_W-1:0] timeout,
  output logic                              flush
);

  logic [TIMEOUT_WIDTH-1:0] limit;
  logic [TIMEOUT_WIDTH-1:0] wait_cnt, wait_cnt_next, wait_eff;
  logic                     armed, armed_next, armed_eff, below;

  // timeout taken modulo the counter width
  generate
    if (TIMEOUT_WIDTH > mts_pkg::TIMEOUT_REG_W) begin : g_ext
      assign limit = {{(TIMEOUT_WIDTH - mts_pkg::TIMEOUT_REG_W){1'b0}}, timeout};
    end else begin : g_trunc
      assign limit = timeout[TIMEOUT_WIDTH-1:0];
    end
  endgenerate

  always_comb begin
    armed_eff = rx || armed;
    wait_eff  = rx ? '0 : wait_cnt;
    below     = (wait_eff < limit);
    flush     = armed_eff && !below;
    if (armed_eff && below) begin
      armed_next    = 1'b1;
      wait_cnt_next = wait_eff + 1'b1;
    end else begin
      armed_next    = 1'b0;
      wait_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= 1'b0;
      wait_cnt <= '0;
    end else if (step) begin
      armed    <= armed_next;
      wait_cnt <= wait_cnt_next;
    end
  end

endmodule

### hw/rtl/mts_cap_watch.sv
module mts_cap_watch #(
  parameter int unsigned CAPTURE_CHANNELS = mts_pkg::CAPTURE_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            sec_tick,
  input  logic [mts_pkg::CAP_IN_W-1:0]    used,
  input  logic [mts_pkg::CAP_IN_W-1:0]    edges,
  input  logic [mts_pkg::CAP_LIMIT_W-1:0] limit,
  output logic [mts_pkg::CAP_IN_W-1:0]    freq_zero
);

  // channels past the mask width can never be used and keep no counter
  localparam int unsigned ACTIVE =
    (CAPTURE_CHANNELS < mts_pkg::CAP_IN_W) ? CAPTURE_CHANNELS : mts_pkg::CAP_IN_W;

  logic [mts_pkg::CAP_LIMIT_W-1:0] silence      [ACTIVE];
  logic [mts_pkg::CAP_LIMIT_W-1:0] silence_next [ACTIVE];
  logic [mts_pkg::CAP_LIMIT_W-1:0] held         [ACTIVE];

  always_comb begin
    freq_zero = '0;
    for (int i = 0; i < ACTIVE; i++) begin
      held[i]         = edges[i] ? '0 : silence[i];
      silence_next[i] = held[i];
      if (sec_tick && used[i]) begin
        if (held[i] < limit) begin
          silence_next[i] = held[i] + 1'b1;
        end else begin
          freq_zero[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ACTIVE; i++) begin
        silence[i] <= '0;
      end
    end else if (step) begin
      for (int i = 0; i < ACTIVE; i++) begin
        silence[i] <= silence_next[i];
      end
    end
  end

endmodule

### hw/rtl/ms_tick_scheduler_with_watchdogs.sv
// a transferred tick is loaded into the input register, then advances into the result register;
//   one tick per cycle sustained while the result side is ready, set by the state update
// throughput is 1 tick per clock while results are taken; a stalled result holds while one more
//   tick waits in the input register, after which the input side stalls too
// reset (rst, synchronous, active high) clears all counters and watchdogs, empties both
//   pipeline registers and restores the configuration registers to their reset values
module ms_tick_scheduler_with_watchdogs #(
  parameter int unsigned CAPTURE_CHANNELS = mts_pkg::CAPTURE_CHANNELS_DEF,
  parameter int unsigned TIMEOUT_WIDTH    = mts_pkg::TIMEOUT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // tick channel
  input  logic                            item_valid,
  output logic                            item_ready,
  input  mts_pkg::item_t                  item,
  // result channel
  output logic                            result_valid,
  input  logic                            result_ready,
  output mts_pkg::result_t                result,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [mts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [mts_pkg::TIMEOUT_REG_W-1:0] com_timeout_ms;
  logic [mts_pkg::CAP_LIMIT_W-1:0]   capture_timeout_s;
  logic                              scan_mode;
  logic                              load_startup;

  // input register
  logic                              s1_valid;
  mts_pkg::item_t                    s1_item;
  logic                              advance;

  // per-tick results from the units
  mts_pkg::tb_status_t               tb_status;
  logic                              com1_flush, com2_flush;
  logic [mts_pkg::CAP_IN_W-1:0]      freq_zero;
  mts_pkg::result_t                  result_next;

  // ---------------------------------------------------------------------------
  // configuration writes; writing the startup delay reloads the countdown
  // ---------------------------------------------------------------------------
  always_comb begin
    load_startup = cfg_we && (mts_pkg::reg_index_t'(cfg_index) == mts_pkg::REG_STARTUP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      com_timeout_ms    <= mts_pkg::COM_TIMEOUT_RST;
      capture_timeout_s <= mts_pkg::CAP_TIMEOUT_RST;
      scan_mode         <= mts_pkg::SCAN_MODE_RST;
    end else if (cfg_we) begin
      case (mts_pkg::reg_index_t'(cfg_index))
        mts_pkg::REG_COM_TIMEOUT: begin
          com_timeout_ms <= cfg_data[mts_pkg::TIMEOUT_REG_W-1:0];
        end
        mts_pkg::REG_CAP_TIMEOUT: begin
          capture_timeout_s <= cfg_data[mts_pkg::CAP_LIMIT_W-1:0];
        end
        mts_pkg::REG_SCAN_MODE: begin
          scan_mode <= cfg_data[0];
        end
        mts_pkg::REG_STARTUP: begin
          // countdown lives in the timebase
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the input register moves into the result register whenever that
  // one is empty or being drained, so a new tick transfers every cycle as long
  // as the result side keeps draining
  always_comb begin
    advance    = s1_valid && (!result_valid || result_ready);
    item_ready = !s1_valid || advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  // ---------------------------------------------------------------------------
  // units; their state steps only when the tick in the input register advances
  // ---------------------------------------------------------------------------
  mts_timebase u_timebase (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .window_start  (s1_item.window_start),
    .scan_mode     (scan_mode),
    .load_startup  (load_startup),
    .startup_value (cfg_data[mts_pkg::STARTUP_W-1:0]),
    .status        (tb_status)
  );

  mts_rx_timeout #(
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_com1 (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx      (s1_item.com1_rx),
    .timeout (com_timeout_ms),
    .flush   (com1_flush)
  );

  mts_rx_timeout #(
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_com2 (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx      (s1_item.com2_rx),
    .timeout (com_timeout_ms),
    .flush   (com2_flush)
  );

  // silence counters are checked only on the tick that completes a second
  mts_cap_watch #(
    .CAPTURE_CHANNELS (CAPTURE_CHANNELS)
  ) u_cap_watch (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .sec_tick  (tb_status.pulse_1s),
    .used      (s1_item.cap_used),
    .edges     (s1_item.cap_edge),
    .limit     (capture_timeout_s),
    .freq_zero (freq_zero)
  );

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_comb begin
    result_next.pulse_10ms   = tb_status.pulse_10ms;
    result_next.pulse_100ms  = tb_status.pulse_100ms;
    result_next.scan_pulse   = tb_status.scan_pulse;
    result_next.pulse_1s     = tb_status.pulse_1s;
    result_next.pulse_1min   = tb_status.pulse_1min;
    result_next.window_done  = tb_status.window_done;
    result_next.com1_flush   = com1_flush;
    result_next.com2_flush   = com2_flush;
    result_next.freq_zero    = freq_zero;
    result_next.startup_left = tb_status.startup_left;
    result_next.seconds_now  = tb_status.seconds_now;
    result_next.minutes_now  = tb_status.minutes_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a minute only completes together with a second
  a_min_with_sec: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pulse_1min |-> result.pulse_1s)
    else $error("minute pulse without second pulse");

  // the second tick is also a 10 ms and 100 ms tick
  a_sec_aligned: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.pulse_1s |-> result.pulse_10ms && result.pulse_100ms)
    else $error("second pulse not aligned with 10 ms and 100 ms pulses");

  // frequency zeroing is only reported on second ticks
  a_fz_on_sec: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.freq_zero != '0) |-> result.pulse_1s)
    else $error("freq_zero set outside a second tick");

  // time of day stays in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.seconds_now < mts_pkg::SEC_W'(mts_pkg::SEC_PER_MIN)) &&
                     (result.minutes_now < mts_pkg::SEC_W'(mts_pkg::MIN_PER_HOUR)))
    else $error("seconds or minutes out of range");

  // the input stage never advances into a stalled result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance |-> !result_valid || result_ready)
    else $error("result overwritten while stalled");

endmodule

### dv/testbench.sv
module testbench;

  // run length guards
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned PRESSURE_AT     = 700;
  localparam int unsigned PRESSURE_CYCLES = 250;

  // shadow timebase: predicts every tick result and checks the block against it
  class timebase_scoreboard;
    // shadow configuration
    logic [mts_pkg::TIMEOUT_REG_W-1:0] com_timeout;
    logic [mts_pkg::CAP_LIMIT_W-1:0]   cap_limit;
    logic                              scan_fast;
    // shadow counters
    logic [mts_pkg::MS_W-1:0]          ms_cnt;
    logic [mts_pkg::SEC_W-1:0]         sec_cnt;
    logic [mts_pkg::SEC_W-1:0]         min_cnt;
    logic                              win_open;
    logic [mts_pkg::WIN_W-1:0]         win_ticks;
    logic                              rx_armed [2];
    logic [mts_pkg::TIMEOUT_REG_W-1:0] rx_wait [2];
    logic [mts_pkg::CAP_LIMIT_W-1:0]   silence [mts_pkg::CAP_IN_W];
    logic [mts_pkg::STARTUP_W-1:0]     startup_cnt;
    mts_pkg::result_t                  due_results [$];
    int unsigned                       mismatches;
    int unsigned                       ticks_checked;

    function new();
      com_timeout   = mts_pkg::COM_TIMEOUT_RST;
      cap_limit     = mts_pkg::CAP_TIMEOUT_RST;
      scan_fast     = mts_pkg::SCAN_MODE_RST;
      startup_cnt   = mts_pkg::STARTUP_RST;
      ms_cnt        = '0;
      sec_cnt       = '0;
      min_cnt       = '0;
      win_open      = 1'b0;
      win_ticks     = '0;
      mismatches    = 0;
      ticks_checked = 0;
      for (int p = 0; p < 2; p++) begin
        rx_armed[p] = 1'b0;
        rx_wait[p]  = '0;
      end
      foreach (silence[i]) silence[i] = '0;
    endfunction

    function void set_reg(mts_pkg::reg_index_t idx, logic [mts_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        mts_pkg::REG_COM_TIMEOUT: com_timeout = val[mts_pkg::TIMEOUT_REG_W-1:0];
        mts_pkg::REG_CAP_TIMEOUT: cap_limit = val[mts_pkg::CAP_LIMIT_W-1:0];
        mts_pkg::REG_SCAN_MODE:   scan_fast = val[0];
        mts_pkg::REG_STARTUP:     startup_cnt = val[mts_pkg::STARTUP_W-1:0];
        default: ;
      endcase
    endfunction

    // one receive watchdog: true on the tick it expires
    function logic rx_step(int port, logic rx);
      if (rx) begin
        rx_armed[port] = 1'b1;
        rx_wait[port]  = '0;
      end
      if (!rx_armed[port]) return 1'b0;
      if (rx_wait[port] < com_timeout) begin
        rx_wait[port]++;
        return 1'b0;
      end
      rx_wait[port]  = '0;
      rx_armed[port] = 1'b0;
      return 1'b1;
    endfunction

    // accepted tick: advance the shadow timebase and queue its result
    function void note_tick(mts_pkg::item_t t);
      mts_pkg::result_t r;
      r = '0;
      for (int i = 0; i < mts_pkg::CAP_IN_W; i++)
        if (t.cap_edge[i]) silence[i] = '0;
      ms_cnt++;
      if (t.window_start) win_open = 1'b1;
      if (win_open) begin
        win_ticks++;
        if (win_ticks >= mts_pkg::WINDOW_TICKS) begin
          win_ticks     = '0;
          win_open      = 1'b0;
          r.window_done = 1'b1;
        end
      end
      r.com1_flush  = rx_step(0, t.com1_rx);
      r.com2_flush  = rx_step(1, t.com2_rx);
      r.pulse_10ms  = (ms_cnt % mts_pkg::MS_DIV_10) == 0;
      r.pulse_100ms = (ms_cnt % mts_pkg::MS_DIV_100) == 0;
      r.scan_pulse  = scan_fast ? r.pulse_10ms : r.pulse_100ms;
      if (ms_cnt >= mts_pkg::MS_PER_SEC) begin
        for (int i = 0; i < mts_pkg::CAP_IN_W; i++) begin
          if (t.cap_used[i]) begin
            if (silence[i] < cap_limit) silence[i]++;
            else r.freq_zero[i] = 1'b1;
          end
        end
        ms_cnt = '0;
        if (startup_cnt != 0) startup_cnt--;
        r.pulse_1s = 1'b1;
        sec_cnt++;
        if (sec_cnt >= mts_pkg::SEC_PER_MIN) begin
          sec_cnt      = '0;
          r.pulse_1min = 1'b1;
          min_cnt++;
          if (min_cnt >= mts_pkg::MIN_PER_HOUR) min_cnt = '0;
        end
      end
      r.startup_left = startup_cnt;
      r.seconds_now  = sec_cnt;
      r.minutes_now  = min_cnt;
      due_results.push_back(r);
    endfunction

    function void log_mismatch(string what, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("tick %0d %s: expected %h, got %h", ticks_checked, what, want, got);
    endfunction

    function void cmp(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) log_mismatch(what, want, got);
    endfunction

    function void check_result(mts_pkg::result_t got);
      mts_pkg::result_t want;
      ticks_checked++;
      if (due_results.size() == 0) begin
        log_mismatch("result with no tick pending", '0, '0);
        return;
      end
      want = due_results.pop_front();
      cmp("pulse_10ms", want.pulse_10ms, got.pulse_10ms);
      cmp("pulse_100ms", want.pulse_100ms, got.pulse_100ms);
      cmp("scan_pulse", want.scan_pulse, got.scan_pulse);
      cmp("pulse_1s", want.pulse_1s, got.pulse_1s);
      cmp("pulse_1min", want.pulse_1min, got.pulse_1min);
      cmp("window_done", want.window_done, got.window_done);
      cmp("com1_flush", want.com1_flush, got.com1_flush);
      cmp("com2_flush", want.com2_flush, got.com2_flush);
      cmp("freq_zero", want.freq_zero, got.freq_zero);
      cmp("startup_left", want.startup_left, got.startup_left);
      cmp("seconds_now", want.seconds_now, got.seconds_now);
      cmp("minutes_now", want.minutes_now, got.minutes_now);
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            item_valid;
  logic                            item_ready;
  mts_pkg::item_t                  item;
  logic                            result_valid;
  logic                            result_ready;
  mts_pkg::result_t                result;
  logic                            cfg_we;
  logic [mts_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mts_pkg::CFG_DATA_W-1:0]  cfg_data;

  timebase_scoreboard sb;
  bit                 idling;       // random gaps allowed on both sides
  int unsigned        ticks_sent;   // tick transfers so far
  int unsigned        cycle_count;

  ms_tick_scheduler_with_watchdogs u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop if the handshakes ever hang
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // random tick: sparse receive bytes, occasional window arming, mixed edge density
  function automatic mts_pkg::item_t random_tick(int unsigned rx_pct);
    mts_pkg::item_t t;
    t.window_start = $urandom_range(0, 99) < 4;
    t.com1_rx      = $urandom_range(0, 99) < rx_pct;
    t.com2_rx      = $urandom_range(0, 99) < rx_pct;
    t.cap_used     = mts_pkg::CAP_IN_W'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: t.cap_edge = '0;
      1: t.cap_edge = mts_pkg::CAP_IN_W'($urandom_range(0, 255));
      default: t.cap_edge = mts_pkg::CAP_IN_W'($urandom & $urandom & $urandom);
    endcase
    return t;
  endfunction

  // offer one tick, maybe after a gap, and hold it until the transfer
  task automatic send_tick(mts_pkg::item_t t, bit may_idle);
    int unsigned gap;
    if (may_idle && $urandom_range(0, 99) < 20) begin
      gap = $urandom_range(1, 11);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= t;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_tick(t);
    ticks_sent++;
  endtask

  // random ticks; gaps only for items in [idle_from, idle_to)
  task automatic run_phase(int unsigned count, int unsigned rx_pct,
                           int unsigned idle_from, int unsigned idle_to);
    for (int unsigned n = 0; n < count; n++) begin
      idling = (n >= idle_from) && (n < idle_to);
      send_tick(random_tick(rx_pct), idling);
    end
    item_valid <= 1'b0;
  endtask

  // every tick yields a result, so an empty queue plus the pipeline depth means idle
  task automatic wait_results_drained();
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all four registers back to back, write enable held high throughout
  task automatic program_regs(logic [15:0] timeout, logic [7:0] cap_s, logic scan,
                              logic [15:0] startup);
    mts_pkg::reg_index_t            order [4];
    logic [mts_pkg::CFG_DATA_W-1:0] vals [4];
    order = '{mts_pkg::REG_COM_TIMEOUT, mts_pkg::REG_CAP_TIMEOUT, mts_pkg::REG_SCAN_MODE,
              mts_pkg::REG_STARTUP};
    vals  = '{timeout, mts_pkg::CFG_DATA_W'(cap_s), mts_pkg::CFG_DATA_W'(scan), startup};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      sb.set_reg(order[k], vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // result side: checks each transfer, random ready bursts, one long hold-off
  initial begin
    int unsigned hold_left;
    bit          held_long;
    hold_left    = 0;
    held_long    = 1'b0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) sb.check_result(result);
      if (hold_left != 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (!held_long && ticks_sent >= PRESSURE_AT) begin
        // long stall while ticks keep coming: pipeline fills and item_ready drops
        held_long = 1'b1;
        hold_left = PRESSURE_CYCLES - 1;
        result_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 99) < 15) begin
        hold_left = $urandom_range(1, 11) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    mts_pkg::item_t corner [10];
    sb         = new();
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    idling     = 1'b0;
    ticks_sent = 0;

    // field extremes, window rearm while open, receive while armed,
    // edge on unused channels, alternating channel masks
    corner[0] = '{1'b0, 1'b0, 1'b0, 8'h00, 8'h00};
    corner[1] = '{1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF};
    corner[2] = '{1'b1, 1'b1, 1'b0, 8'h00, 8'h00};
    corner[3] = '{1'b0, 1'b0, 1'b1, 8'hAA, 8'h55};
    corner[4] = '{1'b0, 1'b1, 1'b1, 8'h55, 8'hAA};
    corner[5] = '{1'b1, 1'b0, 1'b0, 8'hFF, 8'h00};
    corner[6] = '{1'b0, 1'b0, 1'b0, 8'h80, 8'h01};
    corner[7] = '{1'b0, 1'b1, 1'b0, 8'h01, 8'h80};
    corner[8] = '{1'b0, 1'b0, 1'b1, 8'h00, 8'hFF};
    corner[9] = '{1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed ticks under reset configuration
    idling = 1'b1;
    foreach (corner[i]) send_tick(corner[i], 1'b1);
    item_valid <= 1'b0;
    wait_results_drained();

    // zero timeout flushes on the first armed tick, widest limits elsewhere
    program_regs(16'd0, 8'd255, 1'b0, 16'hFFFF);
    run_phase(300, 30, 0, 300);
    wait_results_drained();

    // short timeout, random capture limit, countdown idle at zero; first half back to back
    program_regs(16'($urandom_range(2, 12)), 8'($urandom_range(1, 254)), 1'b1, 16'd0);
    run_phase(300, 8, 150, 300);
    wait_results_drained();

    // spans the first second: zero capture limit reports every used channel,
    // countdown runs out; long stall lands here, final stretch without gaps
    program_regs(16'hFFFF, 8'd0, 1'b0, 16'd1);
    run_phase(550, 20, 0, 400);
    idling = 1'b0;
    wait_results_drained();

    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mts_pkg.sv
hw/rtl/mts_timebase.sv
hw/rtl/mts_rx_timeout.sv
hw/rtl/mts_cap_watch.sv
hw/rtl/ms_tick_scheduler_with_watchdogs.sv
dv/testbench.sv
